/* hw/rtl/pbs_pkg.sv */
// shared types, codes and constants of the poll back-off scheduler
// no dependencies; pbs_front, pbs_back, the top level and the testbench import it
package pbs_pkg;

  localparam int unsigned STATIONS_DEF      = 256;
  localparam int unsigned BACKOFF_STEPS_DEF = 17;
  localparam int unsigned CMD_DEPTH         = 2;
  localparam int unsigned RES_DEPTH         = 2;

  localparam logic [15:0] POLL_INTERVAL_RST = 16'd1800;
  localparam logic [4:0]  UNKNOWN_AFTER_RST = 5'd8;
  localparam logic [5:0]  MAX_POLLS_RST     = 6'd20;
  localparam logic [8:0]  NUM_STATIONS_RST  = 9'd0;
  localparam logic [5:0]  POLL_CAP          = 6'd32;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_REPORT = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_POLL    = 2'd0,
    KIND_RESCHED = 2'd1,
    KIND_QUERY   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_BUSY    = 2'd1,
    ST_UNKNOWN = 2'd2
  } busy_e;

  typedef enum logic [1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_UNKNOWN_AFTER = 2'd1,
    REG_MAX_POLLS     = 2'd2,
    REG_NUM_STATIONS  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [15:0] poll_interval;
    logic [4:0]  unknown_after;
    logic [5:0]  max_polls;
    logic [8:0]  num_stations;
  } cfg_t;

  typedef struct packed {
    func_e       op;
    logic [31:0] now;
    logic [7:0]  station;
    busy_e       state;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  entry;
    logic [15:0] next_timeout;
    busy_e       busy;
    logic [4:0]  count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] rep_time;
    logic [31:0] poll_time;
    logic [4:0]  count;
    busy_e       busy;
  } entry_t;

  // back-off delay in seconds by unanswered poll count
  function automatic logic [11:0] backoff_delay(input logic [4:0] count,
                                                input int unsigned steps);
    logic [4:0] top;
    logic [4:0] c;
    logic [11:0] d;
    top = (steps - 1 > 31) ? 5'd31 : 5'(steps - 1);
    c   = (count > top) ? top : count;
    case (c) inside
      5'd0:           d = 12'd0;
      [5'd1:5'd2]:    d = 12'd5;
      [5'd3:5'd4]:    d = 12'd10;
      [5'd5:5'd6]:    d = 12'd30;
      [5'd7:5'd8]:    d = 12'd60;
      [5'd9:5'd10]:   d = 12'd300;
      [5'd11:5'd12]:  d = 12'd600;
      [5'd13:5'd14]:  d = 12'd1800;
      default:        d = 12'd3600;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/pbs_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module pbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/pbs_fifo.sv */
// small register queue with push/full and pop/empty sides
// no dependencies
module pbs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_en, pop_en;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign push_en = push_i && !full_o;
  assign pop_en  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_en) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_en) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_en && !pop_en) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_en && !push_en) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/pbs_front.sv */
// front end: takes input transfers, sorts them into commands, queues them
// depends on pbs_pkg and pbs_fifo
module pbs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [1:0]     func_i,
  input  logic [31:0]    now_seconds_i,
  input  logic [7:0]     station_i,
  input  logic [1:0]     reported_state_i,
  input  logic           hold_i,
  output logic           full_o,
  output logic           cmd_valid_o,
  output pbs_pkg::cmd_t  cmd_o,
  input  logic           cmd_pop_i
);
  import pbs_pkg::*;

  cmd_t  cmd;
  logic  known;
  logic  q_full, q_empty;
  logic  accept;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    known = 1'b1;
    cmd.op = FUNC_TICK;
    case (func_i)
      FUNC_TICK:   cmd.op = FUNC_TICK;
      FUNC_REPORT: cmd.op = FUNC_REPORT;
      FUNC_QUERY:  cmd.op = FUNC_QUERY;
      default:     known = 1'b0;
    endcase
    cmd.now     = now_seconds_i;
    cmd.station = station_i;
    case (reported_state_i)
      ST_FREE: cmd.state = ST_FREE;
      ST_BUSY: cmd.state = ST_BUSY;
      default: cmd.state = ST_UNKNOWN;
    endcase
  end

  assign full_o = q_full || hold_i;
  assign accept = push_i && !full_o;

  // unused function code is taken and dropped here
  pbs_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && known),
    .wdata_i (cmd),
    .full_o  (q_full),
    .pop_i   (cmd_pop_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = q_rdata;

endmodule

/* hw/rtl/pbs_back.sv */
// back end: station table, clearing pass, scan sequencer and result issue
// depends on pbs_pkg and pbs_ram
module pbs_back #(
  parameter int unsigned Stations     = pbs_pkg::STATIONS_DEF,
  parameter int unsigned BackoffSteps = pbs_pkg::BACKOFF_STEPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pbs_pkg::cfg_t    cfg_i,
  input  logic             cmd_valid_i,
  input  pbs_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_ready_i,
  output logic             res_push_o,
  output pbs_pkg::result_t res_o,
  output logic             clearing_o
);
  import pbs_pkg::*;

  localparam int unsigned IdxW = (Stations > 1) ? $clog2(Stations) : 1;
  localparam int unsigned CntW = ($clog2(Stations + 1) > 9) ? $clog2(Stations + 1) : 9;
  localparam logic [CntW-1:0] StationsCnt = CntW'(Stations);
  localparam logic [IdxW-1:0] LastIdx     = IdxW'(Stations - 1);
  localparam logic [4:0]      SatCnt      =
    (BackoffSteps - 1 > 31) ? 5'd31 : 5'(BackoffSteps - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_RESCH  = 6'b001000,
    S_REPORT = 6'b010000,
    S_QUERY  = 6'b100000
  } bstate_e;

  bstate_e         state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [CntW-1:0] start_q, start_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [15:0]     tmo_q, tmo_d;
  logic [5:0]      sent_q, sent_d;
  logic [31:0]     now_q, now_d;
  logic [7:0]      st_q, st_d;
  busy_e           rep_q, rep_d;
  logic            qhit_q, qhit_d;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t          ent;

  logic [CntW-1:0]    n_eff, ns_ext, st_ext, idx_nxt;
  logic [5:0]         budget, sent_inc;
  logic signed [32:0] since_rep, since_poll;
  logic signed [33:0] due;
  logic [11:0]        dly, dly_new;
  logic [4:0]         cnt_new;
  logic               rep_ok, polled, stall;
  logic [15:0]        tmo_next;
  busy_e              busy_new;

  pbs_ram #(
    .Width ($bits(entry_t)),
    .Depth (Stations)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent        = ram_rdata;
  assign clearing_o = (state_q == S_CLEAR);

  assign ns_ext   = CntW'(cfg_i.num_stations);
  assign n_eff    = (ns_ext > StationsCnt) ? StationsCnt : ns_ext;
  assign st_ext   = CntW'(cmd_i.station);
  assign budget   = (cfg_i.max_polls > POLL_CAP) ? POLL_CAP : cfg_i.max_polls;
  assign sent_inc = sent_q + 6'd1;
  assign idx_nxt  = idx_q + CntW'(1);

  // per-station evaluation on the entry just read
  assign since_rep  = $signed({1'b0, now_q}) - $signed({1'b0, ent.rep_time});
  assign since_poll = $signed({1'b0, now_q}) - $signed({1'b0, ent.poll_time});
  assign dly        = backoff_delay(ent.count, BackoffSteps);
  assign rep_ok     = since_rep >= $signed({17'd0, cfg_i.poll_interval});
  assign polled     = rep_ok && (since_poll >= $signed({21'd0, dly}));
  assign cnt_new    = (ent.count < SatCnt) ? ent.count + 5'd1 : ent.count;
  assign dly_new    = backoff_delay(cnt_new, BackoffSteps);
  assign busy_new   = (ent.count == cfg_i.unknown_after) ? ST_UNKNOWN : ent.busy;
  assign stall      = polled && (sent_inc >= budget);

  // next due time, measured after this station's own update
  always_comb begin
    if (!rep_ok) begin
      due = $signed({2'b0, ent.rep_time}) + $signed({18'd0, cfg_i.poll_interval})
          - $signed({2'b0, now_q});
    end else if (polled) begin
      due = $signed({22'd0, dly_new});
    end else begin
      due = $signed({2'b0, ent.poll_time}) + $signed({22'd0, dly})
          - $signed({2'b0, now_q});
    end
    if (due < 0) begin
      tmo_next = 16'd0;
    end else if (due < $signed({18'd0, tmo_q})) begin
      tmo_next = due[15:0];
    end else begin
      tmo_next = tmo_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    start_d   = start_q;
    idx_d     = idx_q;
    tmo_d     = tmo_q;
    sent_d    = sent_q;
    now_d     = now_q;
    st_d      = st_q;
    rep_d     = rep_q;
    qhit_d    = qhit_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IdxW-1:0];
    ram_wdata = '{rep_time: ent.rep_time, poll_time: now_q, count: cnt_new,
                  busy: busy_new};
    ram_re    = 1'b0;
    ram_raddr = idx_nxt[IdxW-1:0];
    res_push_o = 1'b0;
    res_o     = '{kind: KIND_POLL, entry: idx_q[7:0], next_timeout: 16'd0,
                  busy: ST_FREE, count: 5'd0, last: 1'b0};

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '{rep_time: 32'd0, poll_time: 32'd0, count: 5'd0,
                      busy: ST_UNKNOWN};
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          now_d     = cmd_i.now;
          st_d      = cmd_i.station;
          rep_d     = cmd_i.state;
          ram_raddr = IdxW'(cmd_i.station);
          case (cmd_i.op)
            FUNC_TICK: begin
              tmo_d  = cfg_i.poll_interval;
              sent_d = 6'd0;
              if (start_q < n_eff) begin
                ram_re    = 1'b1;
                ram_raddr = start_q[IdxW-1:0];
                idx_d     = start_q;
                state_d   = S_SCAN;
              end else begin
                start_d = '0;
                state_d = S_RESCH;
              end
            end
            FUNC_REPORT: begin
              if (st_ext < n_eff) begin
                ram_re  = 1'b1;
                state_d = S_REPORT;
              end
            end
            FUNC_QUERY: begin
              ram_re  = 1'b1;
              qhit_d  = st_ext < StationsCnt;
              state_d = S_QUERY;
            end
            default: ;
          endcase
        end
      end

      // one station a cycle unless a poll waits; next read overlaps the check
      S_SCAN: begin
        if (!polled || res_ready_i) begin
          if (polled) begin
            ram_we     = 1'b1;
            res_push_o = 1'b1;
            sent_d     = sent_inc;
          end
          if (stall) begin
            tmo_d   = 16'd1;
            start_d = idx_nxt;
            state_d = S_RESCH;
          end else begin
            tmo_d = tmo_next;
            if (idx_nxt >= n_eff) begin
              start_d = '0;
              state_d = S_RESCH;
            end else begin
              ram_re = 1'b1;
              idx_d  = idx_nxt;
            end
          end
        end
      end

      S_RESCH: begin
        res_o = '{kind: KIND_RESCHED, entry: 8'd0, next_timeout: tmo_q,
                  busy: ST_FREE, count: 5'd0, last: 1'b1};
        if (res_ready_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_REPORT: begin
        ram_we    = 1'b1;
        ram_waddr = IdxW'(st_q);
        ram_wdata = '{rep_time: now_q, poll_time: ent.poll_time, count: 5'd0,
                      busy: rep_q};
        state_d   = S_IDLE;
      end

      S_QUERY: begin
        res_o = '{kind: KIND_QUERY, entry: st_q, next_timeout: 16'd0,
                  busy: qhit_q ? ent.busy : ST_UNKNOWN,
                  count: qhit_q ? ent.count : 5'd0, last: 1'b1};
        if (res_ready_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      start_q <= '0;
      idx_q   <= '0;
      sent_q  <= '0;
      qhit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      start_q <= start_d;
      idx_q   <= idx_d;
      sent_q  <= sent_d;
      qhit_q  <= qhit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmo_q <= tmo_d;
    now_q <= now_d;
    st_q  <= st_d;
    rep_q <= rep_d;
  end

endmodule

/* hw/rtl/poll_backoff_scheduler.sv */
// Poll back-off scheduler, top level: configuration registers, front, back,
// result queue. Depends on pbs_pkg, pbs_front, pbs_back and pbs_fifo.
//
// Usage:
// - input channel is a queue write side: an item transfers when push is high
//   and full is low; func selects tick scan, status report or query
// - results come out of a queue read side: the oldest result is on the
//   result ports while empty is low and transfers when pop is high
// - configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
//   the user is to write it only while the block is idle; the block does not enforce this
// - a status report gives no result; a query gives one result
// - a tick reads one table entry a cycle from the saved start entry through
//   the single table read port, holding on a poll while the result queue is full
// - the last result of every tick or query has last set
// - after reset a clearing pass writes every table entry, one a cycle;
//   full stays high until it is done
// - when the receiver stalls, the result queue fills, the scan holds at the
//   next station it polls, and the command queue fills up before full rises
module poll_backoff_scheduler #(
  parameter int unsigned Stations     = pbs_pkg::STATIONS_DEF,
  parameter int unsigned BackoffSteps = pbs_pkg::BACKOFF_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_seconds_i,
  input  logic [7:0]  station_i,
  input  logic [1:0]  reported_state_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  entry_o,
  output logic [15:0] next_timeout_o,
  output logic [1:0]  busy_state_o,
  output logic [4:0]  poll_count_o,
  output logic        last_o
);
  import pbs_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  logic    clearing;
  logic    res_push, res_full;
  result_t res_in, res_out;
  logic [$bits(result_t)-1:0] res_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_interval <= POLL_INTERVAL_RST;
      cfg_q.unknown_after <= UNKNOWN_AFTER_RST;
      cfg_q.max_polls     <= MAX_POLLS_RST;
      cfg_q.num_stations  <= NUM_STATIONS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POLL_INTERVAL: cfg_q.poll_interval <= cfg_wdata_i;
        REG_UNKNOWN_AFTER: cfg_q.unknown_after <= cfg_wdata_i[4:0];
        REG_MAX_POLLS:     cfg_q.max_polls     <= cfg_wdata_i[5:0];
        REG_NUM_STATIONS:  cfg_q.num_stations  <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  pbs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .func_i           (func_i),
    .now_seconds_i    (now_seconds_i),
    .station_i        (station_i),
    .reported_state_i (reported_state_i),
    .hold_i           (clearing),
    .full_o           (full),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  pbs_back #(
    .Stations     (Stations),
    .BackoffSteps (BackoffSteps)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  pbs_fifo #(
    .Width ($bits(result_t)),
    .Depth (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out        = res_rdata;
  assign kind_o         = res_out.kind;
  assign entry_o        = res_out.entry;
  assign next_timeout_o = res_out.next_timeout;
  assign busy_state_o   = res_out.busy;
  assign poll_count_o   = res_out.count;
  assign last_o         = res_out.last;

endmodule

/* dv/tb_poll_backoff_scheduler.sv */
`timescale 1ns / 100ps
// testbench of poll_backoff_scheduler: directed and random ticks, reports and queries
// depends on pbs_pkg and the block; every result is checked against a scheduler model
module tb_poll_backoff_scheduler;
  import pbs_pkg::*;

  localparam int unsigned NSTA           = STATIONS_DEF;
  localparam int unsigned CNT_SAT        = BACKOFF_STEPS_DEF - 1;
  localparam int unsigned BUDGET_CAP     = 32;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned RX_HOLD_CYCLES = 600;
  localparam int unsigned MAX_PRINTS     = 50;
  localparam logic [1:0]  FUNC_SPARE     = 2'd3;
  localparam logic [1:0]  STATE_ODD      = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now;
    logic [7:0]  station;
    logic [1:0]  state;
  } sched_cmd_t;

  logic        clk_i;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic [1:0]  cfg_idx_i        = '0;
  logic [15:0] cfg_wdata_i      = '0;
  logic        push             = 1'b0;
  logic        full;
  logic [1:0]  func_i           = '0;
  logic [31:0] now_seconds_i    = '0;
  logic [7:0]  station_i        = '0;
  logic [1:0]  reported_state_i = '0;
  logic        empty;
  logic        pop              = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  entry_o;
  logic [15:0] next_timeout_o;
  logic [1:0]  busy_state_o;
  logic [4:0]  poll_count_o;
  logic        last_o;

  poll_backoff_scheduler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .func_i, .now_seconds_i, .station_i, .reported_state_i,
    .empty, .pop, .kind_o, .entry_o, .next_timeout_o, .busy_state_o,
    .poll_count_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // scheduler model: configuration and station table
  logic [15:0] m_interval      = POLL_INTERVAL_RST;
  logic [4:0]  m_unknown_after = UNKNOWN_AFTER_RST;
  logic [5:0]  m_max_polls     = MAX_POLLS_RST;
  logic [8:0]  m_stations      = NUM_STATIONS_RST;
  logic [31:0] m_rep_time  [NSTA];
  logic [31:0] m_poll_time [NSTA];
  logic [4:0]  m_count     [NSTA];
  busy_e       m_busy      [NSTA];
  int unsigned m_scan_start = 0;

  result_t     exp_results[$];
  sched_cmd_t  cmd_backlog[$];
  int unsigned errors      = 0;
  bit          quiet_phase = 1'b0;
  int unsigned hold_req    = 0;
  logic [31:0] wall_clock  = 32'd5000;

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic longint retry_delay(logic [4:0] cnt);
    logic [4:0] c;
    c = (cnt > CNT_SAT) ? 5'(CNT_SAT) : cnt;
    case (c)
      5'd0:         return 0;
      5'd1, 5'd2:   return 5;
      5'd3, 5'd4:   return 10;
      5'd5, 5'd6:   return 30;
      5'd7, 5'd8:   return 60;
      5'd9, 5'd10:  return 300;
      5'd11, 5'd12: return 600;
      5'd13, 5'd14: return 1800;
      default:      return 3600;
    endcase
  endfunction

  function automatic void expect_result(kind_e k, int unsigned ent, longint tmo, busy_e b,
                                        logic [4:0] cnt, logic lst);
    result_t r;
    r.kind         = k;
    r.entry        = ent[7:0];
    r.next_timeout = tmo[15:0];
    r.busy         = b;
    r.count        = cnt;
    r.last         = lst;
    exp_results.push_back(r);
  endfunction

  // advance the model by one accepted command and queue what it must produce
  function automatic void sched_model_apply(sched_cmd_t c);
    int unsigned n, budget, sent, i;
    longint t, iv, since_rep, since_poll, due, tmo;
    bit stalled;
    n = (m_stations > NSTA) ? NSTA : int'(m_stations);
    if (c.func == FUNC_TICK) begin
      budget  = (m_max_polls > BUDGET_CAP) ? BUDGET_CAP : int'(m_max_polls);
      t       = c.now;
      iv      = m_interval;
      tmo     = iv;
      sent    = 0;
      stalled = 1'b0;
      i       = m_scan_start;
      while (i < n && !stalled) begin
        since_rep  = t - longint'(m_rep_time[i]);
        since_poll = t - longint'(m_poll_time[i]);
        if (since_rep >= iv && since_poll >= retry_delay(m_count[i])) begin
          expect_result(KIND_POLL, i, 0, ST_FREE, 5'd0, 1'b0);
          if (m_count[i] == m_unknown_after) m_busy[i] = ST_UNKNOWN;
          if (m_count[i] < CNT_SAT) m_count[i] = m_count[i] + 5'd1;
          m_poll_time[i] = c.now;
          sent++;
          if (sent >= budget) begin
            tmo          = 1;
            m_scan_start = i + 1;
            stalled      = 1'b1;
          end
        end
        if (!stalled) begin
          if (since_rep < iv) due = longint'(m_rep_time[i]) + iv - t;
          else due = longint'(m_poll_time[i]) + retry_delay(m_count[i]) - t;
          if (tmo > due) tmo = due;
        end
        i++;
      end
      if (!stalled) m_scan_start = 0;
      if (tmo < 0) tmo = 0;
      expect_result(KIND_RESCHED, 0, tmo, ST_FREE, 5'd0, 1'b1);
    end else if (c.func == FUNC_REPORT) begin
      if (c.station < n) begin
        m_busy[c.station]      = (c.state > ST_UNKNOWN) ? ST_UNKNOWN : busy_e'(c.state);
        m_rep_time[c.station]  = c.now;
        m_count[c.station]     = 5'd0;
      end
    end else if (c.func == FUNC_QUERY) begin
      expect_result(KIND_QUERY, c.station, 0, m_busy[c.station], m_count[c.station], 1'b1);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic sched_cmd_t mk_cmd(logic [1:0] f, logic [31:0] now, logic [7:0] st,
                                        logic [1:0] s);
    sched_cmd_t c;
    c.func    = f;
    c.now     = now;
    c.station = st;
    c.state   = s;
    return c;
  endfunction

  // command driver
  sched_cmd_t  drv_cmd;
  int unsigned drv_gap = 0;
  bit          drv_offer;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_offer = push;
      if (push && !full) begin
        sched_model_apply(drv_cmd);
        drv_offer = 1'b0;
        drv_gap   = quiet_phase ? 0 : pick_gap();
      end
      if (!drv_offer) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (cmd_backlog.size() > 0) begin
          drv_cmd           = cmd_backlog.pop_front();
          func_i           <= drv_cmd.func;
          now_seconds_i    <= drv_cmd.now;
          station_i        <= drv_cmd.station;
          reported_state_i <= drv_cmd.state;
          drv_offer         = 1'b1;
        end
      end
      push <= drv_offer;
    end
  end

  // result monitor with random pop stalls and one long hold-off on request
  int unsigned rx_stall  = 0;
  int unsigned rx_hold   = 0;
  int unsigned hold_seen = 0;
  bit          rx_pop;
  result_t     rx_want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (exp_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d entry %0d", kind_o, entry_o));
        end else begin
          rx_want = exp_results.pop_front();
          if (kind_o !== rx_want.kind)
            flag_mismatch($sformatf("kind got %0d want %0d", kind_o, rx_want.kind));
          if (entry_o !== rx_want.entry)
            flag_mismatch($sformatf("entry got %0d want %0d", entry_o, rx_want.entry));
          if (next_timeout_o !== rx_want.next_timeout)
            flag_mismatch($sformatf("next_timeout got %0d want %0d",
                                    next_timeout_o, rx_want.next_timeout));
          if (busy_state_o !== rx_want.busy)
            flag_mismatch($sformatf("busy_state got %0d want %0d", busy_state_o, rx_want.busy));
          if (poll_count_o !== rx_want.count)
            flag_mismatch($sformatf("poll_count got %0d want %0d", poll_count_o, rx_want.count));
          if (last_o !== rx_want.last)
            flag_mismatch($sformatf("last got %0d want %0d", last_o, rx_want.last));
        end
        rx_stall = quiet_phase ? 0 : pick_gap();
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        rx_hold   = RX_HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rx_pop = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        rx_pop = 1'b0;
      end else begin
        rx_pop = 1'b1;
      end
      pop <= rx_pop;
    end
  end

  // watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(reg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_POLL_INTERVAL: m_interval      = val;
      REG_UNKNOWN_AFTER: m_unknown_after = val[4:0];
      REG_MAX_POLLS:     m_max_polls     = val[5:0];
      REG_NUM_STATIONS:  m_stations      = val[8:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] iv, logic [4:0] ua, logic [5:0] mp, logic [8:0] ns);
    write_reg(REG_POLL_INTERVAL, iv);
    write_reg(REG_UNKNOWN_AFTER, {11'd0, ua});
    write_reg(REG_MAX_POLLS, {10'd0, mp});
    write_reg(REG_NUM_STATIONS, {7'd0, ns});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every command went in and every result came out, then let the block settle
  task automatic drain();
    while (cmd_backlog.size() != 0 || push || exp_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly time-ordered traffic around the table in use, plus some noise
  task automatic gen_phase(int unsigned count);
    int unsigned j, r, span;
    logic [7:0] st;
    span = (m_stations > 253) ? 255 : int'(m_stations) + 2;
    for (j = 0; j < count; j++) begin
      r = $urandom_range(0, 9);
      if (r < 5) wall_clock = wall_clock + 32'($urandom_range(0, 20));
      else if (r < 8) wall_clock = wall_clock + 32'($urandom_range(0, 700));
      else wall_clock = wall_clock + 32'($urandom_range(0, 4000));
      r = $urandom_range(0, 99);
      if (r < 35) begin
        cmd_backlog.push_back(mk_cmd(FUNC_TICK, wall_clock, 8'($urandom_range(0, 255)),
                                     2'($urandom_range(0, 3))));
      end else if (r < 70) begin
        st = 8'($urandom_range(0, span));
        cmd_backlog.push_back(mk_cmd(FUNC_REPORT, wall_clock, st, 2'($urandom_range(0, 3))));
      end else if (r < 88) begin
        st = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, span))
                                         : 8'($urandom_range(0, 255));
        cmd_backlog.push_back(mk_cmd(FUNC_QUERY, wall_clock, st, 2'($urandom_range(0, 3))));
      end else if (r < 93) begin
        cmd_backlog.push_back(mk_cmd(FUNC_SPARE, $urandom, 8'($urandom_range(0, 255)),
                                     2'($urandom_range(0, 3))));
      end else begin
        cmd_backlog.push_back(mk_cmd(2'($urandom_range(0, 3)), $urandom,
                                     8'($urandom_range(0, 255)), 2'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin
    int unsigned k, ph;
    for (k = 0; k < NSTA; k++) begin
      m_rep_time[k]  = '0;
      m_poll_time[k] = '0;
      m_count[k]     = '0;
      m_busy[k]      = ST_UNKNOWN;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty table, unused function, ignored report
    cmd_backlog.push_back(mk_cmd(FUNC_TICK, 32'd0, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_QUERY, 32'd0, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_QUERY, 32'd0, 8'd255, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_REPORT, 32'd7, 8'd0, ST_BUSY));
    cmd_backlog.push_back(mk_cmd(FUNC_SPARE, 32'hFFFF_FFFF, 8'd255, STATE_ODD));
    drain();

    // zero poll budget, odd reported state, stall on the last entry, time wrap
    set_config(16'd10, 5'd0, 6'd0, 9'd4);
    cmd_backlog.push_back(mk_cmd(FUNC_REPORT, 32'd100, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_REPORT, 32'd100, 8'd1, ST_BUSY));
    cmd_backlog.push_back(mk_cmd(FUNC_REPORT, 32'd100, 8'd2, ST_UNKNOWN));
    cmd_backlog.push_back(mk_cmd(FUNC_REPORT, 32'd100, 8'd3, STATE_ODD));
    cmd_backlog.push_back(mk_cmd(FUNC_TICK, 32'd105, 8'd0, ST_FREE));
    for (k = 0; k < 4; k++) cmd_backlog.push_back(mk_cmd(FUNC_TICK, 32'd110, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_TICK, 32'd111, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_QUERY, 32'd111, 8'd3, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_QUERY, 32'd111, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_REPORT, 32'd111, 8'd200, ST_BUSY));
    cmd_backlog.push_back(mk_cmd(FUNC_TICK, 32'hFFFF_FFFF, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_TICK, 32'hFFFF_FFFF, 8'd0, ST_FREE));
    drain();

    // largest interval, budget and station count above their caps
    set_config(16'hFFFF, 5'd16, 6'd63, 9'd300);
    cmd_backlog.push_back(mk_cmd(FUNC_TICK, 32'hFFFF_FFFF, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_TICK, 32'hFFFF_FFFF, 8'd0, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_QUERY, 32'd0, 8'd40, ST_FREE));
    cmd_backlog.push_back(mk_cmd(FUNC_QUERY, 32'd0, 8'd255, ST_FREE));
    drain();

    for (ph = 0; ph < 5; ph++) begin
      quiet_phase = (ph == 2);
      case (ph)
        0: begin
          // saved start lies beyond the shrunken table
          set_config(16'd1, 5'd16, 6'd32, 9'd3);
          cmd_backlog.push_back(mk_cmd(FUNC_TICK, wall_clock, 8'd0, ST_FREE));
        end
        1: set_config(16'($urandom_range(5, 300)), 5'($urandom_range(0, 8)),
                      6'($urandom_range(1, 4)), 9'($urandom_range(1, 16)));
        2: set_config(16'($urandom_range(60, 1800)), 5'($urandom_range(0, 16)),
                      6'($urandom_range(1, 32)), 9'($urandom_range(8, 24)));
        3: set_config(16'd30, 5'd2, 6'd20, 9'd256);
        default: set_config(16'($urandom_range(1, 120)), 5'($urandom_range(0, 16)),
                            6'($urandom_range(0, 6)), 9'($urandom_range(0, 12)));
      endcase
      gen_phase(25);
      // receiver backs off for a long stretch while commands keep coming
      if (ph == 1) hold_req++;
      drain();
    end

    if (exp_results.size() != 0)
      flag_mismatch($sformatf("%0d results never delivered", exp_results.size()));
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
